// File: rtl/selm_pkg.sv
// Shared types, constants and helpers of the shared/exclusive latch manager.
// Used by every module in rtl but selm_held_ram; depends on nothing.
`default_nettype none
package selm_pkg;

    localparam int NUM_LATCHES      = 16;
    localparam int NUM_PROCS        = 4;
    localparam int THREADS_PER_PROC = 8;
    localparam int HELD_LIST_DEPTH  = 8;
    localparam int COUNT_WIDTH      = 8;

    localparam int NUM_CALLERS = NUM_PROCS * THREADS_PER_PROC;
    localparam int LATCH_W     = $clog2(NUM_LATCHES);
    localparam int PROC_W      = $clog2(NUM_PROCS);
    localparam int THREAD_W    = $clog2(THREADS_PER_PROC);
    localparam int CALLER_W    = PROC_W + THREAD_W;
    localparam int IDX_W       = $clog2(HELD_LIST_DEPTH);
    localparam int TOP_W       = IDX_W + 1;
    localparam int HADDR_W     = CALLER_W + IDX_W;
    localparam int HDATA_W     = LATCH_W + COUNT_WIDTH;

    localparam int W_EXCL_BIT = 0;
    localparam int W_INST_BIT = 1;

    typedef logic [LATCH_W-1:0]     latch_t;
    typedef logic [CALLER_W-1:0]    caller_t;
    typedef logic [CALLER_W:0]      qptr_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [TOP_W-1:0]       top_t;
    typedef logic [IDX_W-1:0]       idx_t;

    localparam qptr_t  QPTR_NONE = {1'b1, {CALLER_W{1'b0}}};
    localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam top_t   TOP_FULL  = top_t'(HELD_LIST_DEPTH);

    localparam logic [1:0] FUNC_ACQUIRE     = 2'd0;
    localparam logic [1:0] FUNC_RELEASE     = 2'd1;
    localparam logic [1:0] FUNC_RELEASE_ALL = 2'd2;
    localparam logic [1:0] FUNC_UNKNOWN     = 2'd3;

    typedef enum logic [1:0] {
        MODE_FREE   = 2'd0,
        MODE_SHARED = 2'd1,
        MODE_EXCL   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_GRANTED     = 3'd0,
        ST_BUSY        = 3'd1,
        ST_QUEUED      = 3'd2,
        ST_BAD_CONVERT = 3'd3,
        ST_BAD_RELEASE = 3'd4,
        ST_LIST_FULL   = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIND_INIT,
        S_FIND_TEST,
        S_FIND_RD,
        S_FIND_CHK,
        S_ACQ,
        S_REL_CHK,
        S_REL_FOUND,
        S_POP_TEST,
        S_POP_RD,
        S_POP_CHK,
        S_POST_REL,
        S_WALK,
        S_REL_END,
        S_RALL_INIT,
        S_RALL_TEST,
        S_RALL_RD,
        S_RALL_CHK,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                kind;
        status_t             status;
        logic [PROC_W-1:0]   woken_proc;
        logic [THREAD_W-1:0] woken_thread;
        logic                last;
    } res_t;

    function automatic count_t sat_inc(input count_t v);
        sat_inc = (v == COUNT_MAX) ? v : count_t'(v + 1'b1);
    endfunction

endpackage
`default_nettype wire

// File: rtl/selm_held_ram.sv
// Generic single-port-write, registered-read RAM for the held-latch lists.
// Stand-alone; no package needed.
`default_nettype none
module selm_held_ram #(
    parameter int DATA_W = 12,
    parameter int ADDR_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/selm_result_reg.sv
// Output register that parts the sequencer from the result channel.
// Depends on selm_pkg for the result type.
`default_nettype none
module selm_result_reg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             res_valid,
    input  wire selm_pkg::res_t                   res,
    output logic                                  res_ready,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  kind,
    output logic [2:0]                            status,
    output logic [selm_pkg::PROC_W-1:0]           woken_proc,
    output logic [selm_pkg::THREAD_W-1:0]         woken_thread,
    output logic                                  last
);
    import selm_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t data_reg;

    assign res_ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign out_valid    = valid_reg;
    assign kind         = data_reg.kind;
    assign status       = data_reg.status;
    assign woken_proc   = data_reg.woken_proc;
    assign woken_thread = data_reg.woken_thread;
    assign last         = data_reg.last;

endmodule
`default_nettype wire

// File: rtl/selm_seq.sv
// Request sequencer: latch table, wait queues, held-list search and walk.
// Depends on selm_pkg and selm_held_ram.
`default_nettype none
module selm_seq (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [1:0]                       func,
    input  wire logic [selm_pkg::PROC_W-1:0]      proc_index,
    input  wire logic [selm_pkg::THREAD_W-1:0]    thread_index,
    input  wire logic [selm_pkg::LATCH_W-1:0]     latch_id,
    input  wire logic                             req_mode,
    input  wire logic [2:0]                       req_condition,
    input  wire logic                             also_release,
    input  wire logic [selm_pkg::LATCH_W-1:0]     release_latch_id,
    output logic                                  res_valid,
    input  wire logic                             res_ready,
    output selm_pkg::res_t                        res
);
    import selm_pkg::*;

    mode_t   latch_mode_reg  [NUM_LATCHES];
    count_t  latch_count_reg [NUM_LATCHES];
    caller_t latch_owner_reg [NUM_LATCHES];
    qptr_t   queue_head_reg  [NUM_LATCHES];
    caller_t queue_tail_reg  [NUM_LATCHES];
    qptr_t      waiter_next_reg [NUM_CALLERS];
    logic [1:0] waiter_mode_reg [NUM_CALLERS];
    logic       waiting_reg     [NUM_CALLERS];
    top_t       held_top_reg    [NUM_CALLERS];

    state_t     state_reg, state_next;
    logic [1:0] func_reg, func_next;
    caller_t    caller_reg, caller_next;
    logic       excl_reg, excl_next;
    logic       inst_reg, inst_next;
    logic       uncond_reg, uncond_next;
    logic       also_reg, also_next;
    latch_t     rel_reg, rel_next;
    latch_t     cur_latch_reg, cur_latch_next;
    status_t    status_reg, status_next;
    logic       self_woken_reg, self_woken_next;
    logic       find_rel_reg, find_rel_next;
    top_t       fi_reg, fi_next;
    logic       found_reg, found_next;
    idx_t       idx_reg, idx_next;
    count_t     hcount_reg, hcount_next;
    top_t       ri_reg, ri_next;
    caller_t    x_reg, x_next;
    logic       found_g_reg, found_g_next;
    logic       ok_reg, ok_next;

    logic    lm_we, lc_we, lo_we, qh_we, qt_we;
    mode_t   lm_wd;
    count_t  lc_wd;
    caller_t lo_wd;
    qptr_t   qh_wd;
    caller_t qt_wd;
    logic    na_we, nb_we, wt_we, wt_wd, wm_we, ht_we;
    caller_t na_addr, nb_addr, wt_addr;
    qptr_t   na_wd, nb_wd;
    logic [1:0] wm_wd;
    top_t    ht_wd;

    logic                ram_we;
    logic [HADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [HDATA_W-1:0]  ram_wd, ram_rd;
    latch_t              rd_latch;
    count_t              rd_count;

    caller_t    in_caller;
    mode_t      cur_mode;
    count_t     cur_count;
    caller_t    cur_owner;
    qptr_t      cur_head;
    caller_t    cur_tail;
    top_t       top_c;
    qptr_t      x_link;
    logic [1:0] x_mode;
    state_t     find_done;

    logic acq_wait, acq_conv, acq_record, acq_full;
    logic rel_bad;
    logic walk_stop, walk_emit, walk_go, walk_first, walk_excl_end, walk_tail_end;

    selm_held_ram #(
        .DATA_W(HDATA_W),
        .ADDR_W(HADDR_W)
    ) u_held_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wd),
        .raddr(ram_raddr),
        .rdata(ram_rd)
    );

    assign rd_latch  = ram_rd[HDATA_W-1:COUNT_WIDTH];
    assign rd_count  = ram_rd[COUNT_WIDTH-1:0];
    assign in_caller = {proc_index, thread_index};
    assign cur_mode  = latch_mode_reg[cur_latch_reg];
    assign cur_count = latch_count_reg[cur_latch_reg];
    assign cur_owner = latch_owner_reg[cur_latch_reg];
    assign cur_head  = queue_head_reg[cur_latch_reg];
    assign cur_tail  = queue_tail_reg[cur_latch_reg];
    assign top_c     = held_top_reg[caller_reg];
    assign x_link    = waiter_next_reg[x_reg];
    assign x_mode    = waiter_mode_reg[x_reg];
    assign find_done = find_rel_reg ? S_REL_FOUND : S_ACQ;
    assign in_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        unique case (cur_mode)
            MODE_FREE:   acq_wait = 1'b0;
            MODE_EXCL:   acq_wait = (cur_owner != caller_reg);
            MODE_SHARED: acq_wait = excl_reg;
            default:     acq_wait = 1'b0;
        endcase
    end

    assign acq_conv   = (cur_mode == MODE_SHARED) && excl_reg
                        && !(also_reg && (rel_reg == cur_latch_reg))
                        && found_reg && (hcount_reg != '0);
    assign acq_record = !inst_reg && (!acq_wait || uncond_reg);
    assign acq_full   = acq_record && !found_reg && (top_c >= TOP_FULL);
    assign rel_bad    = (cur_count == '0) || (cur_mode == MODE_FREE)
                        || ((cur_mode == MODE_EXCL) && (cur_owner != caller_reg));

    assign walk_stop     = found_g_reg && x_mode[W_EXCL_BIT];
    assign walk_emit     = (x_reg != caller_reg);
    assign walk_go       = !walk_stop && (!walk_emit || res_ready);
    assign walk_first    = !found_g_reg && !x_mode[W_INST_BIT];
    assign walk_excl_end = walk_first && x_mode[W_EXCL_BIT];
    assign walk_tail_end = x_link[CALLER_W];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (func == FUNC_UNKNOWN || waiting_reg[in_caller])
                        state_next = S_EMIT;
                    else if (func == FUNC_ACQUIRE)
                        state_next = S_FIND_INIT;
                    else if (func == FUNC_RELEASE)
                        state_next = S_REL_CHK;
                    else
                        state_next = S_RALL_INIT;
                end
            end
            S_FIND_INIT: state_next = S_FIND_TEST;
            S_FIND_TEST: state_next = (fi_reg == '0) ? find_done : S_FIND_RD;
            S_FIND_RD:   state_next = S_FIND_CHK;
            S_FIND_CHK:  state_next = (rd_latch == cur_latch_reg) ? find_done : S_FIND_TEST;
            S_ACQ:
            begin
                if (acq_conv || acq_full || !also_reg)
                    state_next = S_EMIT;
                else
                    state_next = S_REL_CHK;
            end
            S_REL_CHK:   state_next = rel_bad ? S_REL_END : S_FIND_INIT;
            S_REL_FOUND:
            begin
                priority if (!found_reg || hcount_reg == '0)
                    state_next = S_REL_END;
                else if (top_t'({1'b0, idx_reg} + 1'b1) == top_c)
                    state_next = S_POP_TEST;
                else
                    state_next = S_POST_REL;
            end
            S_POP_TEST:  state_next = (top_c == '0) ? S_POST_REL : S_POP_RD;
            S_POP_RD:    state_next = S_POP_CHK;
            S_POP_CHK:   state_next = (rd_count == '0) ? S_POP_TEST : S_POST_REL;
            S_POST_REL:
            begin
                if (cur_count == '0 && !cur_head[CALLER_W])
                    state_next = S_WALK;
                else
                    state_next = S_REL_END;
            end
            S_WALK:
            begin
                if (walk_stop || (walk_go && (walk_excl_end || walk_tail_end)))
                    state_next = S_REL_END;
            end
            S_REL_END:
            begin
                if (func_reg == FUNC_RELEASE_ALL && ok_reg)
                    state_next = S_RALL_RD;
                else
                    state_next = S_EMIT;
            end
            S_RALL_INIT: state_next = S_RALL_TEST;
            S_RALL_TEST: state_next = (ri_reg == '0) ? S_EMIT : S_RALL_RD;
            S_RALL_RD:   state_next = S_RALL_CHK;
            S_RALL_CHK:  state_next = (rd_count != '0) ? S_REL_CHK : S_RALL_TEST;
            S_EMIT:      state_next = res_ready ? S_IDLE : S_EMIT;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        func_next       = func_reg;
        caller_next     = caller_reg;
        excl_next       = excl_reg;
        inst_next       = inst_reg;
        uncond_next     = uncond_reg;
        also_next       = also_reg;
        rel_next        = rel_reg;
        cur_latch_next  = cur_latch_reg;
        status_next     = status_reg;
        self_woken_next = self_woken_reg;
        find_rel_next   = find_rel_reg;
        fi_next         = fi_reg;
        found_next      = found_reg;
        idx_next        = idx_reg;
        hcount_next     = hcount_reg;
        ri_next         = ri_reg;
        x_next          = x_reg;
        found_g_next    = found_g_reg;
        ok_next         = ok_reg;

        lm_we = 1'b0;  lm_wd = MODE_FREE;
        lc_we = 1'b0;  lc_wd = '0;
        lo_we = 1'b0;  lo_wd = caller_reg;
        qh_we = 1'b0;  qh_wd = QPTR_NONE;
        qt_we = 1'b0;  qt_wd = '0;
        na_we = 1'b0;  na_addr = caller_reg;  na_wd = QPTR_NONE;
        nb_we = 1'b0;  nb_addr = cur_tail;    nb_wd = {1'b0, caller_reg};
        wt_we = 1'b0;  wt_addr = caller_reg;  wt_wd = 1'b0;
        wm_we = 1'b0;  wm_wd = '0;
        ht_we = 1'b0;  ht_wd = top_c;
        ram_we    = 1'b0;
        ram_waddr = {caller_reg, idx_reg};
        ram_wd    = {cur_latch_reg, hcount_reg};
        ram_raddr = {caller_reg, fi_reg[IDX_W-1:0] - 1'b1};

        res_valid        = 1'b0;
        res.kind         = 1'b0;
        res.status       = status_reg;
        res.woken_proc   = '0;
        res.woken_thread = '0;
        res.last         = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                func_next       = func;
                caller_next     = in_caller;
                excl_next       = req_mode;
                inst_next       = req_condition[2];
                uncond_next     = req_condition[1];
                also_next       = also_release;
                rel_next        = release_latch_id;
                cur_latch_next  = latch_id;
                self_woken_next = 1'b0;
                find_rel_next   = 1'b0;
                priority if (func == FUNC_UNKNOWN)
                    status_next = ST_BAD_RELEASE;
                else if (waiting_reg[in_caller])
                    status_next = ST_BUSY;
                else
                    status_next = ST_GRANTED;
            end
            S_FIND_INIT:
            begin
                fi_next    = top_c;
                found_next = 1'b0;
            end
            S_FIND_CHK:
            begin
                if (rd_latch == cur_latch_reg)
                begin
                    found_next  = 1'b1;
                    idx_next    = fi_reg[IDX_W-1:0] - 1'b1;
                    hcount_next = rd_count;
                end
                else
                begin
                    fi_next = fi_reg - 1'b1;
                end
            end
            S_ACQ:
            begin
                priority if (acq_conv)
                begin
                    status_next = ST_BAD_CONVERT;
                end
                else if (acq_full)
                begin
                    status_next = ST_LIST_FULL;
                end
                else
                begin
                    if (!inst_reg && !acq_wait)
                    begin
                        lc_we = 1'b1;
                        if (cur_mode == MODE_FREE)
                        begin
                            lm_we = 1'b1;
                            lm_wd = excl_reg ? MODE_EXCL : MODE_SHARED;
                            lc_wd = count_t'(1);
                            lo_we = 1'b1;
                        end
                        else
                        begin
                            lc_wd = sat_inc(cur_count);
                        end
                    end
                    if (acq_record)
                    begin
                        ram_we = 1'b1;
                        if (found_reg)
                        begin
                            ram_waddr = {caller_reg, idx_reg};
                            ram_wd    = {cur_latch_reg, sat_inc(hcount_reg)};
                        end
                        else
                        begin
                            ram_waddr = {caller_reg, top_c[IDX_W-1:0]};
                            ram_wd    = {cur_latch_reg, count_t'(1)};
                            ht_we     = 1'b1;
                            ht_wd     = top_c + 1'b1;
                        end
                    end
                    if (acq_wait && uncond_reg)
                    begin
                        wm_we = 1'b1;
                        wm_wd = {inst_reg, excl_reg};
                        na_we = 1'b1;
                        if (cur_head[CALLER_W])
                        begin
                            qh_we = 1'b1;
                            qh_wd = {1'b0, caller_reg};
                        end
                        else
                        begin
                            nb_we = 1'b1;
                        end
                        qt_we = 1'b1;
                        qt_wd = caller_reg;
                        wt_we = 1'b1;
                        wt_wd = 1'b1;
                    end
                    if (acq_wait)
                        status_next = uncond_reg ? ST_QUEUED : ST_BUSY;
                    else
                        status_next = ST_GRANTED;
                    cur_latch_next = rel_reg;
                end
            end
            S_REL_CHK:
            begin
                ok_next       = 1'b0;
                find_rel_next = 1'b1;
            end
            S_REL_FOUND:
            begin
                if (found_reg && hcount_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = {caller_reg, idx_reg};
                    ram_wd    = {cur_latch_reg, count_t'(hcount_reg - 1'b1)};
                    lc_we     = 1'b1;
                    lc_wd     = cur_count - 1'b1;
                end
            end
            S_POP_RD:
            begin
                ram_raddr = {caller_reg, top_c[IDX_W-1:0] - 1'b1};
            end
            S_POP_CHK:
            begin
                if (rd_count == '0)
                begin
                    ht_we = 1'b1;
                    ht_wd = top_c - 1'b1;
                end
            end
            S_POST_REL:
            begin
                ok_next      = 1'b1;
                x_next       = cur_head[CALLER_W-1:0];
                found_g_next = 1'b0;
                if (cur_count == '0 && cur_head[CALLER_W])
                begin
                    lm_we = 1'b1;
                    lm_wd = MODE_FREE;
                end
            end
            S_WALK:
            begin
                if (walk_stop)
                begin
                    qh_we = 1'b1;
                    qh_wd = {1'b0, x_reg};
                end
                else if (walk_go)
                begin
                    res_valid        = walk_emit;
                    res.kind         = 1'b1;
                    res.status       = ST_GRANTED;
                    res.woken_proc   = x_reg[CALLER_W-1:THREAD_W];
                    res.woken_thread = x_reg[THREAD_W-1:0];
                    res.last         = 1'b0;
                    if (!walk_emit)
                        self_woken_next = 1'b1;
                    wt_we   = 1'b1;
                    wt_addr = x_reg;
                    wt_wd   = 1'b0;
                    na_we   = 1'b1;
                    na_addr = x_reg;
                    na_wd   = QPTR_NONE;
                    if (walk_first)
                    begin
                        found_g_next = 1'b1;
                        lm_we = 1'b1;
                        lc_we = 1'b1;
                        lc_wd = count_t'(1);
                        if (x_mode[W_EXCL_BIT])
                        begin
                            lm_wd = MODE_EXCL;
                            lo_we = 1'b1;
                            lo_wd = x_reg;
                        end
                        else
                        begin
                            lm_wd = MODE_SHARED;
                        end
                    end
                    else if (found_g_reg && !x_mode[W_INST_BIT])
                    begin
                        lc_we = 1'b1;
                        lc_wd = sat_inc(cur_count);
                    end
                    if (walk_excl_end || walk_tail_end)
                    begin
                        qh_we = 1'b1;
                        qh_wd = x_link;
                        if (walk_tail_end)
                        begin
                            qt_we = 1'b1;
                            qt_wd = '0;
                        end
                        if (!found_g_reg && !walk_first)
                        begin
                            lm_we = 1'b1;
                            lm_wd = MODE_FREE;
                        end
                    end
                    else
                    begin
                        x_next = x_link[CALLER_W-1:0];
                    end
                end
            end
            S_REL_END:
            begin
                priority if (func_reg == FUNC_ACQUIRE)
                begin
                    if (!ok_reg)
                        status_next = ST_BAD_RELEASE;
                    else if (self_woken_reg)
                        status_next = ST_GRANTED;
                end
                else if (func_reg == FUNC_RELEASE)
                begin
                    status_next = ok_reg ? ST_GRANTED : ST_BAD_RELEASE;
                end
                else
                begin
                    if (!ok_reg)
                        status_next = ST_BAD_RELEASE;
                end
            end
            S_RALL_INIT:
            begin
                ri_next = top_c;
            end
            S_RALL_RD:
            begin
                ram_raddr = {caller_reg, ri_reg[IDX_W-1:0] - 1'b1};
            end
            S_RALL_CHK:
            begin
                if (rd_count != '0)
                    cur_latch_next = rd_latch;
                else
                    ri_next = ri_reg - 1'b1;
            end
            S_EMIT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            func_reg       <= '0;
            caller_reg     <= '0;
            excl_reg       <= 1'b0;
            inst_reg       <= 1'b0;
            uncond_reg     <= 1'b0;
            also_reg       <= 1'b0;
            rel_reg        <= '0;
            cur_latch_reg  <= '0;
            status_reg     <= ST_GRANTED;
            self_woken_reg <= 1'b0;
            find_rel_reg   <= 1'b0;
            fi_reg         <= '0;
            found_reg      <= 1'b0;
            idx_reg        <= '0;
            hcount_reg     <= '0;
            ri_reg         <= '0;
            x_reg          <= '0;
            found_g_reg    <= 1'b0;
            ok_reg         <= 1'b0;
            for (int i = 0; i < NUM_LATCHES; i++)
            begin
                latch_mode_reg[i]  <= MODE_FREE;
                latch_count_reg[i] <= '0;
                latch_owner_reg[i] <= '0;
                queue_head_reg[i]  <= QPTR_NONE;
                queue_tail_reg[i]  <= '0;
            end
            for (int i = 0; i < NUM_CALLERS; i++)
            begin
                waiter_next_reg[i] <= QPTR_NONE;
                waiting_reg[i]     <= 1'b0;
                held_top_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            func_reg       <= func_next;
            caller_reg     <= caller_next;
            excl_reg       <= excl_next;
            inst_reg       <= inst_next;
            uncond_reg     <= uncond_next;
            also_reg       <= also_next;
            rel_reg        <= rel_next;
            cur_latch_reg  <= cur_latch_next;
            status_reg     <= status_next;
            self_woken_reg <= self_woken_next;
            find_rel_reg   <= find_rel_next;
            fi_reg         <= fi_next;
            found_reg      <= found_next;
            idx_reg        <= idx_next;
            hcount_reg     <= hcount_next;
            ri_reg         <= ri_next;
            x_reg          <= x_next;
            found_g_reg    <= found_g_next;
            ok_reg         <= ok_next;
            if (lm_we) latch_mode_reg[cur_latch_reg]  <= lm_wd;
            if (lc_we) latch_count_reg[cur_latch_reg] <= lc_wd;
            if (lo_we) latch_owner_reg[cur_latch_reg] <= lo_wd;
            if (qh_we) queue_head_reg[cur_latch_reg]  <= qh_wd;
            if (qt_we) queue_tail_reg[cur_latch_reg]  <= qt_wd;
            if (na_we) waiter_next_reg[na_addr]       <= na_wd;
            if (nb_we) waiter_next_reg[nb_addr]       <= nb_wd;
            if (wt_we) waiting_reg[wt_addr]           <= wt_wd;
            if (ht_we) held_top_reg[caller_reg]       <= ht_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wm_we)
        begin
            waiter_mode_reg[caller_reg] <= wm_wd;
        end
    end

endmodule
`default_nettype wire

// File: rtl/shared_exclusive_latch_manager_top.sv
// A rejected request goes straight from idle to its status transfer. An acquire or
// release tests, reads and checks each held-list entry searched and each entry popped,
// then wakes the waiters one by one (held while the result channel stalls) and sends its status.
// One request at a time: the next is taken after the status.
// Reset: rst_n clears the latch table, queues and list tops at once; no sweep.
// Depends on selm_pkg, selm_seq, selm_result_reg.
`default_nettype none
module shared_exclusive_latch_manager_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [1:0]                       func,
    input  wire logic [selm_pkg::PROC_W-1:0]      proc_index,
    input  wire logic [selm_pkg::THREAD_W-1:0]    thread_index,
    input  wire logic [selm_pkg::LATCH_W-1:0]     latch_id,
    input  wire logic                             req_mode,
    input  wire logic [2:0]                       req_condition,
    input  wire logic                             also_release,
    input  wire logic [selm_pkg::LATCH_W-1:0]     release_latch_id,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  kind,
    output logic [2:0]                            status,
    output logic [selm_pkg::PROC_W-1:0]           woken_proc,
    output logic [selm_pkg::THREAD_W-1:0]         woken_thread,
    output logic                                  last
);
    import selm_pkg::*;

    logic res_valid;
    logic res_ready;
    res_t res;

    selm_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .proc_index      (proc_index),
        .thread_index    (thread_index),
        .latch_id        (latch_id),
        .req_mode        (req_mode),
        .req_condition   (req_condition),
        .also_release    (also_release),
        .release_latch_id(release_latch_id),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    selm_result_reg u_result_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res         (res),
        .res_ready   (res_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .status      (status),
        .woken_proc  (woken_proc),
        .woken_thread(woken_thread),
        .last        (last)
    );

    a_wake_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind) |-> (!last && status == ST_GRANTED))
        else $error("wake notice marked last or carries a status");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kind) |-> last)
        else $error("caller status not marked last");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after a transfer");

endmodule
`default_nettype wire

// File: dv/selm_checker.sv
// Transfer monitor, latch-table predictor and result comparator for the latch manager.
// Depends on selm_pkg; instantiated beside the block by shared_exclusive_latch_manager_top_tb.
`timescale 1ns / 100ps
module selm_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic [1:0]                    func,
    input  wire logic [selm_pkg::PROC_W-1:0]   proc_index,
    input  wire logic [selm_pkg::THREAD_W-1:0] thread_index,
    input  wire logic [selm_pkg::LATCH_W-1:0]  latch_id,
    input  wire logic                          req_mode,
    input  wire logic [2:0]                    req_condition,
    input  wire logic                          also_release,
    input  wire logic [selm_pkg::LATCH_W-1:0]  release_latch_id,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic                          kind,
    input  wire logic [2:0]                    status,
    input  wire logic [selm_pkg::PROC_W-1:0]   woken_proc,
    input  wire logic [selm_pkg::THREAD_W-1:0] woken_thread,
    input  wire logic                          last,
    output int                                 fail_count,
    output int                                 pending
);
    import selm_pkg::*;

    localparam int NIL      = -1;
    localparam int MAX_RES  = 32;
    localparam int CNT_TOP  = (1 << COUNT_WIDTH) - 1;
    localparam int WAIT_EX  = 1;
    localparam int WAIT_IN  = 2;

    int  latch_state [NUM_LATCHES];
    int  latch_grants[NUM_LATCHES];
    int  latch_holder[NUM_LATCHES];
    int  wait_head   [NUM_LATCHES];
    int  wait_tail   [NUM_LATCHES];
    int  wait_link   [NUM_CALLERS];
    int  wait_flags  [NUM_CALLERS];
    bit  is_waiting  [NUM_CALLERS];
    int  held_id     [NUM_CALLERS][HELD_LIST_DEPTH];
    int  held_cnt    [NUM_CALLERS][HELD_LIST_DEPTH];
    int  held_depth  [NUM_CALLERS];
    bit  self_wake;
    int  req_results;
    res_t grant_results[$];

    function automatic int bump(input int v);
        return (v < CNT_TOP) ? v + 1 : v;
    endfunction

    function automatic void note_result(input bit k, input int st, input int who,
                                        input bit fin);
        res_t r;
        if (req_results >= MAX_RES) return;
        r.kind         = k;
        r.status       = status_t'(st[2:0]);
        r.woken_proc   = k ? PROC_W'(who / THREADS_PER_PROC) : '0;
        r.woken_thread = k ? THREAD_W'(who % THREADS_PER_PROC) : '0;
        r.last         = fin;
        grant_results.push_back(r);
        req_results++;
    endfunction

    function automatic int held_slot(input int c, input int l);
        for (int i = held_depth[c] - 1; i >= 0; i--)
            if (held_id[c][i] == l) return i;
        return NIL;
    endfunction

    function automatic void wake_waiters(input int l, input int c);
        int h;
        int t;
        int g;
        int x;
        int nx;
        h = wait_head[l];
        t = h;
        if ((wait_flags[h] & WAIT_IN) != 0)
        begin
            t = wait_link[h];
            while (t != NIL && (wait_flags[t] & WAIT_IN) != 0) t = wait_link[t];
        end
        if (t != NIL && (wait_flags[t] & WAIT_EX) == 0)
            while (wait_link[t] != NIL && (wait_flags[wait_link[t]] & WAIT_EX) == 0)
                t = wait_link[t];
        if (t != NIL)
        begin
            wait_head[l] = wait_link[t];
            wait_link[t] = NIL;
        end
        else
            wait_head[l] = NIL;
        if (wait_head[l] == NIL) wait_tail[l] = 0;

        g = h;
        while (g != NIL && (wait_flags[g] & WAIT_IN) != 0) g = wait_link[g];
        if (g == NIL)
            latch_state[l] = MODE_FREE;
        else if ((wait_flags[g] & WAIT_EX) != 0)
        begin
            latch_state[l]  = MODE_EXCL;
            latch_grants[l] = 1;
            latch_holder[l] = g;
        end
        else
        begin
            latch_state[l] = MODE_SHARED;
            for (x = g; x != NIL; x = wait_link[x])
                if ((wait_flags[x] & WAIT_IN) == 0) latch_grants[l] = bump(latch_grants[l]);
        end

        for (x = h; x != NIL; x = nx)
        begin
            nx = wait_link[x];
            wait_link[x] = NIL;
            is_waiting[x] = 1'b0;
            if (x == c) self_wake = 1'b1;
            else note_result(1'b1, ST_GRANTED, x, 1'b0);
        end
    endfunction

    function automatic bit drop_latch(input int c, input int l);
        int idx;
        if (latch_grants[l] == 0 || latch_state[l] == MODE_FREE) return 1'b0;
        if (latch_state[l] == MODE_EXCL && latch_holder[l] != c) return 1'b0;
        idx = held_slot(c, l);
        if (idx < 0 || held_cnt[c][idx] == 0) return 1'b0;
        held_cnt[c][idx]--;
        if (idx + 1 == held_depth[c])
            while (held_depth[c] > 0 && held_cnt[c][held_depth[c] - 1] == 0) held_depth[c]--;
        latch_grants[l]--;
        if (latch_grants[l] == 0)
        begin
            if (wait_head[l] == NIL) latch_state[l] = MODE_FREE;
            else wake_waiters(l, c);
        end
        return 1'b1;
    endfunction

    function automatic int take_latch(input int c, input int l, input bit excl,
                                      input int cond, input bit also, input int rel);
        bit inst;
        bit uncond;
        bit must_wait;
        bit record;
        int m;
        int idx;
        int st;
        inst      = (cond & 4) != 0;
        uncond    = (cond & 2) != 0;
        must_wait = 1'b1;
        idx       = NIL;
        m         = latch_state[l];
        if (m == MODE_FREE)
            must_wait = 1'b0;
        else if (m == MODE_EXCL)
        begin
            if (latch_holder[l] == c) must_wait = 1'b0;
        end
        else if (!excl)
            must_wait = 1'b0;
        else if (!(also && rel == l))
        begin
            idx = held_slot(c, l);
            if (idx >= 0 && held_cnt[c][idx] > 0) return ST_BAD_CONVERT;
        end

        if (!inst)
        begin
            record = !must_wait || uncond;
            if (record)
            begin
                idx = held_slot(c, l);
                if (idx < 0 && held_depth[c] >= HELD_LIST_DEPTH) return ST_LIST_FULL;
            end
            if (!must_wait)
            begin
                if (m == MODE_FREE)
                begin
                    latch_state[l]  = excl ? MODE_EXCL : MODE_SHARED;
                    latch_grants[l] = 1;
                    latch_holder[l] = c;
                end
                else
                    latch_grants[l] = bump(latch_grants[l]);
            end
            if (record)
            begin
                if (idx >= 0)
                    held_cnt[c][idx] = bump(held_cnt[c][idx]);
                else
                begin
                    held_id[c][held_depth[c]]  = l;
                    held_cnt[c][held_depth[c]] = 1;
                    held_depth[c]++;
                end
            end
        end

        if (must_wait && uncond)
        begin
            wait_flags[c] = (excl ? WAIT_EX : 0) | (inst ? WAIT_IN : 0);
            wait_link[c]  = NIL;
            if (wait_head[l] == NIL) wait_head[l] = c;
            else wait_link[wait_tail[l]] = c;
            wait_tail[l]  = c;
            is_waiting[c] = 1'b1;
        end

        st = must_wait ? (uncond ? ST_QUEUED : ST_BUSY) : ST_GRANTED;
        if (also)
        begin
            if (!drop_latch(c, rel)) st = ST_BAD_RELEASE;
            else if (self_wake) st = ST_GRANTED;
        end
        return st;
    endfunction

    function automatic void predict_request();
        int c;
        int st;
        req_results = 0;
        self_wake   = 1'b0;
        st          = ST_GRANTED;
        c           = int'(proc_index) * THREADS_PER_PROC + int'(thread_index);
        if (func == FUNC_UNKNOWN)
            st = ST_BAD_RELEASE;
        else if (is_waiting[c])
            st = ST_BUSY;
        else if (func == FUNC_ACQUIRE)
            st = take_latch(c, latch_id, req_mode, req_condition, also_release,
                            release_latch_id);
        else if (func == FUNC_RELEASE)
        begin
            if (!drop_latch(c, latch_id)) st = ST_BAD_RELEASE;
        end
        else
        begin
            for (int i = held_depth[c] - 1; i >= 0 && st == ST_GRANTED; i--)
                while (held_cnt[c][i] > 0)
                    if (!drop_latch(c, held_id[c][i]))
                    begin
                        st = ST_BAD_RELEASE;
                        break;
                    end
        end
        note_result(1'b0, st, 0, 1'b1);
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("%0t: result mismatch on %s: got %0d, expected %0d", $realtime, what,
                 got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LATCHES; i++)
            begin
                latch_state[i]  = MODE_FREE;
                latch_grants[i] = 0;
                latch_holder[i] = 0;
                wait_head[i]    = NIL;
                wait_tail[i]    = 0;
            end
            for (int i = 0; i < NUM_CALLERS; i++)
            begin
                wait_link[i]  = NIL;
                wait_flags[i] = 0;
                is_waiting[i] = 1'b0;
                held_depth[i] = 0;
                for (int j = 0; j < HELD_LIST_DEPTH; j++)
                begin
                    held_id[i][j]  = 0;
                    held_cnt[i][j] = 0;
                end
            end
            grant_results.delete();
            fail_count = 0;
            pending    <= 0;
        end
        else
        begin
            res_t want;
            if (in_valid && !in_stall) predict_request();
            if (out_valid && !out_stall)
            begin
                if (grant_results.size() == 0)
                    report("unexpected transfer (kind)", kind, 0);
                else
                begin
                    want = grant_results.pop_front();
                    if (kind != want.kind) report("kind", kind, want.kind);
                    if (status != want.status) report("status", status, want.status);
                    if (woken_proc != want.woken_proc)
                        report("woken_proc", woken_proc, want.woken_proc);
                    if (woken_thread != want.woken_thread)
                        report("woken_thread", woken_thread, want.woken_thread);
                    if (last != want.last) report("last", last, want.last);
                end
            end
            pending <= grant_results.size();
        end
    end

endmodule

// File: dv/shared_exclusive_latch_manager_top_tb.sv
// Stimulus and verdict for shared_exclusive_latch_manager_top: directed latch scenarios,
// then random requests under three idle/stall profiles. Depends on selm_pkg, selm_checker.
`timescale 1ns / 100ps
module shared_exclusive_latch_manager_top_tb;
    import selm_pkg::*;

    localparam logic [2:0] COND_NONE    = 3'd0;
    localparam logic [2:0] COND_TRY     = 3'd1;
    localparam logic [2:0] COND_WAIT    = 3'd2;
    localparam logic [2:0] COND_BOTH    = 3'd3;
    localparam logic [2:0] COND_INSTANT = 3'd4;
    localparam logic       SHARED       = 1'b0;
    localparam logic       EXCLUSIVE    = 1'b1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          func = '0;
    logic [PROC_W-1:0]   proc_index = '0;
    logic [THREAD_W-1:0] thread_index = '0;
    logic [LATCH_W-1:0]  latch_id = '0;
    logic                req_mode = 1'b0;
    logic [2:0]          req_condition = '0;
    logic                also_release = 1'b0;
    logic [LATCH_W-1:0]  release_latch_id = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                kind;
    logic [2:0]          status;
    logic [PROC_W-1:0]   woken_proc;
    logic [THREAD_W-1:0] woken_thread;
    logic                last;
    int                  fail_count;
    int                  pending;
    int                  send_idle = 0;
    int                  recv_idle = 0;

    always #4 clk = ~clk;

    shared_exclusive_latch_manager_top u_top (.*);
    selm_checker u_checker (.*);

    always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle);

    task automatic issue(input logic [1:0] f, input int p, input int t, input int l,
                         input logic m, input logic [2:0] c, input logic a, input int r);
        func             <= f;
        proc_index       <= PROC_W'(p);
        thread_index     <= THREAD_W'(t);
        latch_id         <= LATCH_W'(l);
        req_mode         <= m;
        req_condition    <= c;
        also_release     <= a;
        release_latch_id <= LATCH_W'(r);
        in_valid         <= 1'b1;
        forever
        begin
            @(negedge clk);
            if (!in_stall) break;
        end
        @(posedge clk);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic random_request();
        logic [1:0] f;
        int         p;
        int         t;
        int         sel;
        sel = $urandom_range(99);
        f   = (sel < 55) ? FUNC_ACQUIRE : (sel < 87) ? FUNC_RELEASE :
              (sel < 96) ? FUNC_RELEASE_ALL : FUNC_UNKNOWN;
        if ($urandom_range(99) < 75)
        begin
            p = $urandom_range(1);
            t = $urandom_range(3);
        end
        else
        begin
            p = $urandom_range(NUM_PROCS - 1);
            t = $urandom_range(THREADS_PER_PROC - 1);
        end
        issue(f, p, t,
              ($urandom_range(99) < 75) ? $urandom_range(3) : $urandom_range(NUM_LATCHES - 1),
              1'($urandom_range(1)), 3'($urandom_range(7)), ($urandom_range(99) < 25),
              ($urandom_range(99) < 75) ? $urandom_range(3) : $urandom_range(NUM_LATCHES - 1));
    endtask

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle = 24;
        recv_idle = 72;

        issue(FUNC_UNKNOWN, 0, 0, 0, SHARED, COND_NONE, 1'b0, 0);
        issue(FUNC_ACQUIRE, 3, 7, 15, EXCLUSIVE, COND_TRY, 1'b0, 0);
        issue(FUNC_ACQUIRE, 0, 0, 15, SHARED, COND_TRY, 1'b0, 0);
        issue(FUNC_ACQUIRE, 0, 0, 15, SHARED, COND_WAIT, 1'b0, 0);
        issue(FUNC_RELEASE, 0, 0, 15, SHARED, COND_NONE, 1'b0, 0);
        issue(FUNC_ACQUIRE, 3, 7, 15, EXCLUSIVE, COND_BOTH, 1'b0, 0);
        issue(FUNC_RELEASE, 3, 7, 15, SHARED, COND_NONE, 1'b0, 0);
        issue(FUNC_RELEASE, 3, 7, 15, SHARED, COND_NONE, 1'b0, 0);
        issue(FUNC_RELEASE, 0, 0, 15, SHARED, COND_NONE, 1'b0, 0);
        issue(FUNC_RELEASE, 0, 0, 15, SHARED, COND_NONE, 1'b0, 0);
        for (int i = 0; i <= HELD_LIST_DEPTH; i++)
            issue(FUNC_ACQUIRE, 1, 1, i, SHARED, COND_NONE, 1'b0, 0);
        issue(FUNC_ACQUIRE, 1, 1, 0, EXCLUSIVE, COND_TRY, 1'b0, 0);
        issue(FUNC_ACQUIRE, 2, 2, 1, EXCLUSIVE, COND_INSTANT | COND_TRY, 1'b0, 0);
        issue(FUNC_ACQUIRE, 2, 2, 1, EXCLUSIVE, COND_INSTANT | COND_WAIT, 1'b0, 0);
        issue(FUNC_ACQUIRE, 1, 1, 2, EXCLUSIVE, COND_WAIT, 1'b1, 2);
        issue(FUNC_ACQUIRE, 1, 1, 3, SHARED, COND_TRY, 1'b1, 12);
        issue(FUNC_RELEASE_ALL, 1, 1, 0, SHARED, COND_NONE, 1'b0, 0);
        issue(FUNC_RELEASE_ALL, 2, 2, 0, SHARED, COND_NONE, 1'b0, 0);

        for (int i = 0; i < 470; i++)
        begin
            if (i == 160)
            begin
                send_idle = 72;
                recv_idle = 24;
            end
            else if (i == 320)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            random_request();
        end
        in_valid <= 1'b0;

        forever
        begin
            @(negedge clk);
            if (pending == 0) break;
        end
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
rtl/selm_pkg.sv
rtl/selm_held_ram.sv
rtl/selm_result_reg.sv
rtl/selm_seq.sv
rtl/shared_exclusive_latch_manager_top.sv
dv/selm_checker.sv
dv/shared_exclusive_latch_manager_top_tb.sv
